// ===== hw/rtl/bmf_pkg.sv =====
// Shared constants and control types for the box mean filter.
package bmf_pkg;

    // Default sizing of the frame store and the window.
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_KERNEL = 32;
    localparam int DEF_CHANNELS   = 3;

    // Fixed field widths of the streams.
    localparam int IO_CH     = 3;
    localparam int SAMPLE_W  = 16;
    localparam int MEAN_W    = 24;
    localparam int POS_W     = 11;
    localparam int FRAC_W    = 8;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 96;

    // Configuration register file.
    localparam int KS_W       = 6;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [KS_W-1:0]  KERNEL_RST = 6'd25;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd2048;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd2048;

    // Input kind carried in tuser.
    localparam logic MODE_PIXEL = 1'b0;

    // Strobes from the sequencer to every channel lane.
    typedef struct packed {
        logic pix_we;
        logic rd_issue;
        logic cs_clear;
        logic cs_commit;
        logic ws_clear;
        logic sub_apply;
        logic div_start;
    } lane_ctl_t;

endpackage

// ===== hw/rtl/box_mean_filter_border_normalized.sv =====
// Top level: frame sequencer, channel lanes and the merging output register.
// A result leaves once its window is complete; its work is the columns summed over
// the window rows, then the divider and control.
// The first result of a row sums up to k/2+1 columns; others sum at most one column.
// The column loop over the row store read port sets the rate; one item at a time.
// Reset (aresetn low, synchronous) restores the control registers and restarts the frame.
module box_mean_filter_border_normalized #(
    parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = bmf_pkg::DEF_MAX_KERNEL,
    parameter int CHANNELS   = bmf_pkg::DEF_CHANNELS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // chan_a [15:0], chan_b [31:16], chan_c [47:32]
    input  logic [bmf_pkg::S_DATA_W-1:0]    s_tdata,
    // mode [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mean_a [23:0], mean_b [47:24], mean_c [71:48], pixel_row [82:72],
    // pixel_col [93:83], zero [95:94]
    output logic [bmf_pkg::M_DATA_W-1:0]    m_tdata,
    // frame_end
    output logic                            m_tlast
);

    localparam int SR    = MAX_KERNEL + 1;
    localparam int SW    = $clog2(SR);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HHW   = $clog2(MAX_HEIGHT + 1);
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int AW    = $clog2(SR * MAX_WIDTH);
    localparam int CNTW  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int PW    = ((WW > HHW) ? WW : HHW) + 1;
    localparam int LANES = (CHANNELS < bmf_pkg::IO_CH) ? CHANNELS : bmf_pkg::IO_CH;
    localparam int MW    = bmf_pkg::MEAN_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_COL    = 4'd2;
    localparam logic [3:0] ST_COLEND = 4'd3;
    localparam logic [3:0] ST_SUBRD  = 4'd4;
    localparam logic [3:0] ST_SUB    = 4'd5;
    localparam logic [3:0] ST_DIVS   = 4'd6;
    localparam logic [3:0] ST_DIVW   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0]                   state_reg, state_next;
    logic [bmf_pkg::KS_W-1:0]     ks_reg, ks_next;
    logic [bmf_pkg::DIM_W-1:0]    wd_reg, wd_next;
    logic [bmf_pkg::DIM_W-1:0]    ht_reg, ht_next;
    logic [RW-1:0]                in_row_reg, in_row_next;
    logic [XW-1:0]                in_col_reg, in_col_next;
    logic [SW-1:0]                in_slot_reg, in_slot_next;
    logic                         in_done_reg, in_done_next;
    logic [RW-1:0]                er_reg, er_next;
    logic [XW-1:0]                ec_reg, ec_next;
    logic [SW-1:0]                em_slot_reg, em_slot_next;
    logic [SW-1:0]                r0slot_reg, r0slot_next;
    logic [SW-1:0]                slot_reg, slot_next;
    logic [KW-1:0]                nr_reg, nr_next;
    logic [KW-1:0]                ri_reg, ri_next;
    logic [XW-1:0]                x_reg, x_next;
    logic [XW-1:0]                xlast_reg, xlast_next;
    logic [XW-1:0]                c0_reg, c0_next;
    logic                         sub_reg, sub_next;
    logic [CNTW-1:0]              cnt_reg, cnt_next;
    logic                         m_valid_reg, m_valid_next;
    logic [3*MW-1:0]              mean_reg, mean_next;
    logic [bmf_pkg::POS_W-1:0]    orow_reg, orow_next;
    logic [bmf_pkg::POS_W-1:0]    ocol_reg, ocol_next;
    logic                         olast_reg, olast_next;

    logic [KW-1:0]                k_eff, hi, lo;
    logic [WW-1:0]                w_eff;
    logic [HHW-1:0]               h_eff;
    logic [PW-1:0]                er_p, ec_p, r1_p, c1_p, r0_p, c0_p, ir_p, ic_p;
    logic                         ready, grow, sub_now, last;
    logic [SW:0]                  dslot, r0slot_c;
    logic [KW:0]                  nrows, ncols;
    logic [RW-1:0]                wr_row;
    logic [XW-1:0]                wr_col;
    logic [SW-1:0]                wr_slot;
    logic                         restart;

    bmf_pkg::lane_ctl_t           ctl;
    logic [AW-1:0]                pix_addr, rd_addr;
    logic [XW-1:0]                sub_x;
    logic [LANES-1:0]             div_done;
    logic [MW-1:0]                lane_mean [LANES];
    logic                         div_all;

    // Effective register values with out-of-range codes mapped.
    always_comb begin
        if (ks_reg == '0) begin
            k_eff = KW'(1);
        end else if (32'(ks_reg) > MAX_KERNEL) begin
            k_eff = KW'(MAX_KERNEL);
        end else begin
            k_eff = KW'(ks_reg);
        end
        if (wd_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(wd_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(wd_reg);
        end
        if (ht_reg == '0) begin
            h_eff = HHW'(1);
        end else if (32'(ht_reg) > MAX_HEIGHT) begin
            h_eff = HHW'(MAX_HEIGHT);
        end else begin
            h_eff = HHW'(ht_reg);
        end
        hi = k_eff >> 1;
        lo = (k_eff - 1'b1) >> 1;
    end

    // Window bounds of the next result, clipped at the frame edges.
    always_comb begin
        er_p = PW'(er_reg);
        ec_p = PW'(ec_reg);
        ir_p = PW'(in_row_reg);
        ic_p = PW'(in_col_reg);
        r1_p = (er_p + PW'(hi) > PW'(h_eff) - 1'b1) ? PW'(h_eff) - 1'b1 : er_p + PW'(hi);
        c1_p = (ec_p + PW'(hi) > PW'(w_eff) - 1'b1) ? PW'(w_eff) - 1'b1 : ec_p + PW'(hi);
        r0_p = (er_p >= PW'(lo)) ? er_p - PW'(lo) : '0;
        c0_p = (ec_p >= PW'(lo)) ? ec_p - PW'(lo) : '0;
        ready = in_done_reg || (ir_p > r1_p) || ((ir_p == r1_p) && (ic_p > c1_p));
        grow  = (ec_p + PW'(hi)) < PW'(w_eff);
        sub_now = (ec_reg != '0) && (c0_p != '0);
        nrows = (KW+1)'(r1_p - r0_p) + 1'b1;
        ncols = (KW+1)'(c1_p - c0_p) + 1'b1;
        dslot = (SW+1)'(er_p - r0_p);
        r0slot_c = ({1'b0, em_slot_reg} >= dslot) ? {1'b0, em_slot_reg} - dslot
                                                  : {1'b0, em_slot_reg} + (SW+1)'(SR) - dslot;
        last  = (WW'(ec_reg) == w_eff - 1'b1) && (HHW'(er_reg) == h_eff - 1'b1);
    end

    // A pixel after a finished frame starts a new frame at the origin.
    always_comb begin
        wr_row  = in_done_reg ? '0 : in_row_reg;
        wr_col  = in_done_reg ? '0 : in_col_reg;
        wr_slot = in_done_reg ? '0 : in_slot_reg;
    end

    assign pix_addr = AW'(wr_slot) * AW'(MAX_WIDTH) + AW'(wr_col);
    assign rd_addr  = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(x_reg);
    assign sub_x    = c0_reg - 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign div_all  = &div_done;

    // Sequencer: pixel write, readiness check, column sums, update, divide, emit.
    always_comb begin
        state_next   = state_reg;
        ks_next      = ks_reg;
        wd_next      = wd_reg;
        ht_next      = ht_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        in_slot_next = in_slot_reg;
        in_done_next = in_done_reg;
        er_next      = er_reg;
        ec_next      = ec_reg;
        em_slot_next = em_slot_reg;
        r0slot_next  = r0slot_reg;
        slot_next    = slot_reg;
        nr_next      = nr_reg;
        ri_next      = ri_reg;
        x_next       = x_reg;
        xlast_next   = xlast_reg;
        c0_next      = c0_reg;
        sub_next     = sub_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mean_next    = mean_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        olast_next   = olast_reg;
        restart      = 1'b0;
        ctl          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == bmf_pkg::MODE_PIXEL) begin
                        ctl.pix_we = 1'b1;
                        if (in_done_reg) begin
                            er_next      = '0;
                            ec_next      = '0;
                            em_slot_next = '0;
                        end
                        in_done_next = 1'b0;
                        in_row_next  = wr_row;
                        in_slot_next = wr_slot;
                        in_col_next  = wr_col + 1'b1;
                        if (WW'(wr_col) + 1'b1 >= w_eff) begin
                            in_col_next  = '0;
                            in_row_next  = wr_row + 1'b1;
                            in_slot_next = (wr_slot == SW'(SR - 1)) ? '0 : wr_slot + 1'b1;
                            if (HHW'(wr_row) + 1'b1 >= h_eff) begin
                                in_row_next  = '0;
                                in_slot_next = '0;
                                in_done_next = 1'b1;
                            end
                        end
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                ctl.cs_clear = 1'b1;
                cnt_next     = CNTW'(nrows * ncols);
                r0slot_next  = SW'(r0slot_c);
                slot_next    = SW'(r0slot_c);
                nr_next      = KW'(r1_p - r0_p);
                ri_next      = '0;
                c0_next      = XW'(c0_p);
                sub_next     = sub_now;
                if (!ready) begin
                    state_next = ST_IDLE;
                end else if (ec_reg == '0) begin
                    ctl.ws_clear = 1'b1;
                    x_next       = '0;
                    xlast_next   = XW'(c1_p);
                    state_next   = ST_COL;
                end else if (grow) begin
                    x_next     = XW'(c1_p);
                    xlast_next = XW'(c1_p);
                    state_next = ST_COL;
                end else begin
                    state_next = sub_now ? ST_SUBRD : ST_DIVS;
                end
            end
            ST_COL: begin
                ctl.rd_issue = 1'b1;
                slot_next    = (slot_reg == SW'(SR - 1)) ? '0 : slot_reg + 1'b1;
                ri_next      = ri_reg + 1'b1;
                if (ri_reg == nr_reg) begin
                    state_next = ST_COLEND;
                end
            end
            ST_COLEND: begin
                ctl.cs_commit = 1'b1;
                if (x_reg != xlast_reg) begin
                    x_next     = x_reg + 1'b1;
                    slot_next  = r0slot_reg;
                    ri_next    = '0;
                    state_next = ST_COL;
                end else begin
                    state_next = sub_reg ? ST_SUBRD : ST_DIVS;
                end
            end
            ST_SUBRD: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                ctl.sub_apply = 1'b1;
                state_next    = ST_DIVS;
            end
            ST_DIVS: begin
                ctl.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_all) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    mean_next    = '0;
                    for (int i = 0; i < LANES; i++) begin
                        mean_next[i*MW +: MW] = lane_mean[i];
                    end
                    orow_next  = bmf_pkg::POS_W'(er_reg);
                    ocol_next  = bmf_pkg::POS_W'(ec_reg);
                    olast_next = last;
                    if (last) begin
                        restart = 1'b1;
                    end else if (WW'(ec_reg) + 1'b1 == w_eff) begin
                        ec_next      = '0;
                        er_next      = er_reg + 1'b1;
                        em_slot_next = (em_slot_reg == SW'(SR - 1)) ? '0 : em_slot_reg + 1'b1;
                    end else begin
                        ec_next = ec_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes; every write restarts the frame.
        if (cfg_we) begin
            unique case (cfg_index)
                bmf_pkg::REG_KERNEL: ks_next = bmf_pkg::KS_W'(cfg_data);
                bmf_pkg::REG_WIDTH:  wd_next = cfg_data;
                bmf_pkg::REG_HEIGHT: ht_next = cfg_data;
                default: ;
            endcase
            restart = 1'b1;
        end

        if (restart) begin
            in_row_next  = '0;
            in_col_next  = '0;
            in_slot_next = '0;
            in_done_next = 1'b0;
            er_next      = '0;
            ec_next      = '0;
            em_slot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ks_reg      <= bmf_pkg::KERNEL_RST;
            wd_reg      <= bmf_pkg::WIDTH_RST;
            ht_reg      <= bmf_pkg::HEIGHT_RST;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            in_slot_reg <= '0;
            in_done_reg <= 1'b0;
            er_reg      <= '0;
            ec_reg      <= '0;
            em_slot_reg <= '0;
            ri_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ks_reg      <= ks_next;
            wd_reg      <= wd_next;
            ht_reg      <= ht_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            in_slot_reg <= in_slot_next;
            in_done_reg <= in_done_next;
            er_reg      <= er_next;
            ec_reg      <= ec_next;
            em_slot_reg <= em_slot_next;
            ri_reg      <= ri_next;
            m_valid_reg <= m_valid_next;
        end
        r0slot_reg <= r0slot_next;
        slot_reg   <= slot_next;
        nr_reg     <= nr_next;
        x_reg      <= x_next;
        xlast_reg  <= xlast_next;
        c0_reg     <= c0_next;
        sub_reg    <= sub_next;
        cnt_reg    <= cnt_next;
        mean_reg   <= mean_next;
        orow_reg   <= orow_next;
        ocol_reg   <= ocol_next;
        olast_reg  <= olast_next;
    end

    // Channel lanes working side by side.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bmf_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .pix_addr (pix_addr),
            .pix_data (s_tdata[g*bmf_pkg::SAMPLE_W +: bmf_pkg::SAMPLE_W]),
            .rd_addr  (rd_addr),
            .col_x    (x_reg),
            .sub_x    (sub_x),
            .cnt      (cnt_reg),
            .mean     (lane_mean[g]),
            .div_done (div_done[g])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, ocol_reg, orow_reg, mean_reg};
    assign m_tlast  = olast_reg;

    // Row sweep never runs past the window height.
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COL) |-> (ri_reg <= nr_reg))
        else $error("row counter ran past window");

    // Ring slots stay inside the row store.
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(in_slot_reg) < SR) && (32'(em_slot_reg) < SR))
        else $error("row slot out of range");

    // All lane dividers finish together.
    a_div_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (&div_done) == (|div_done))
        else $error("lane dividers out of step");

    // An emitted result appears in the output register.
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_tready)) |=> m_valid_reg)
        else $error("result not presented");

endmodule

// ===== hw/rtl/bmf_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module bmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bmf_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module bmf_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Shift in the next dividend bit and subtract where it fits.
    always_comb begin
        trial     = {rem_reg, q_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = '0;
            den_next  = den;
            q_next    = num;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            q_next   = {q_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/bmf_lane.sv =====
// One channel lane: row store, column sums, window sum and mean divider.
module bmf_lane #(
    parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = bmf_pkg::DEF_MAX_KERNEL
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  bmf_pkg::lane_ctl_t                          ctl,
    input  logic [$clog2((MAX_KERNEL+1)*MAX_WIDTH)-1:0] pix_addr,
    input  logic [bmf_pkg::SAMPLE_W-1:0]                pix_data,
    input  logic [$clog2((MAX_KERNEL+1)*MAX_WIDTH)-1:0] rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]                col_x,
    input  logic [$clog2(MAX_WIDTH)-1:0]                sub_x,
    input  logic [$clog2(MAX_KERNEL*MAX_KERNEL+1)-1:0]  cnt,
    output logic [bmf_pkg::MEAN_W-1:0]                  mean,
    output logic                                        div_done
);

    localparam int SR    = MAX_KERNEL + 1;
    localparam int KB    = $clog2(MAX_KERNEL);
    localparam int SUMW  = bmf_pkg::SAMPLE_W + KB;
    localparam int WSW   = bmf_pkg::SAMPLE_W + 2 * KB;
    localparam int NUMW  = WSW + bmf_pkg::FRAC_W;
    localparam int CNTW  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);

    logic [bmf_pkg::SAMPLE_W-1:0] rs_q;
    logic [SUMW-1:0]              cq;
    logic                         pend_reg;
    logic [SUMW-1:0]              cs_reg, cs_next, cs_now;
    logic [WSW-1:0]               ws_reg, ws_next;
    logic [NUMW-1:0]              num;
    logic [NUMW-1:0]              quo;

    // Recent rows of this channel.
    bmf_ram #(.WIDTH(bmf_pkg::SAMPLE_W), .DEPTH(SR * MAX_WIDTH)) u_rows (
        .aclk  (aclk),
        .we    (ctl.pix_we),
        .waddr (pix_addr),
        .wdata (pix_data),
        .raddr (rd_addr),
        .rdata (rs_q)
    );

    // Column sums of the current output row.
    bmf_ram #(.WIDTH(SUMW), .DEPTH(MAX_WIDTH)) u_cols (
        .aclk  (aclk),
        .we    (ctl.cs_commit),
        .waddr (col_x),
        .wdata (cs_now),
        .raddr (sub_x),
        .rdata (cq)
    );

    // Column accumulator takes the sample that the previous cycle read.
    always_comb begin
        cs_now  = cs_reg + (pend_reg ? SUMW'(rs_q) : '0);
        cs_next = (ctl.cs_clear || ctl.cs_commit) ? '0 : cs_now;
        ws_next = ws_reg;
        if (ctl.ws_clear) begin
            ws_next = '0;
        end else if (ctl.cs_commit) begin
            ws_next = ws_reg + WSW'(cs_now);
        end else if (ctl.sub_apply) begin
            ws_next = ws_reg - WSW'(cq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= ctl.rd_issue;
        end
        cs_reg <= cs_next;
        ws_reg <= ws_next;
    end

    // Rounded mean: (sum * 256 + count / 2) / count.
    assign num = {ws_reg, {bmf_pkg::FRAC_W{1'b0}}} + NUMW'(cnt >> 1);

    bmf_div #(.NUM_W(NUMW), .DEN_W(CNTW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.div_start),
        .num     (num),
        .den     (cnt),
        .quo     (quo),
        .done    (div_done)
    );

    assign mean = bmf_pkg::MEAN_W'(quo);

endmodule
